>>> rtl/core/assert_macros.svh
// Assertion helper macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication assertion, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// clocked next-cycle implication assertion, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/core/olc_pkg.sv
// ---------------------------------------------------------------------------
// olc_pkg
// Shared constants and types for the leader clustering unit.
// ---------------------------------------------------------------------------
package olc_pkg;
    localparam int MaxClusters = 64;
    localparam int FrameBits   = 16;
    localparam int FracBits    = 8;
    localparam int CtrW        = FrameBits + FracBits;
    localparam int IdxW        = $clog2(MaxClusters);
    localparam int NumW        = IdxW + 1;
    localparam int CntW        = 16;
    localparam int RegW        = 24;
    localparam int CfgIdxW     = 2;
    localparam int DivW        = CntW + 1;

    localparam logic [CfgIdxW-1:0] CfgPeriod = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgSVar   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgEVar   = 2'd2;

    typedef struct packed {
        logic [CtrW-1:0] cs;
        logic [CtrW-1:0] ce;
        logic [CntW-1:0] cnt;
        logic            vld;
    } t_entry;

    // control from sequencer into the chain
    typedef struct packed {
        logic            shift;  // rotate the ring by one cell
        logic            wr;     // replace head entry
        t_entry          wdata;
    } t_chain_ctl;
endpackage

>>> rtl/core/olc_cell.sv
// ---------------------------------------------------------------------------
// olc_cell
// One storage cell of the cluster ring: holds one entry, passes it on.
// ---------------------------------------------------------------------------
module olc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  olc_pkg::t_entry i_prev,
    output olc_pkg::t_entry o_entry
);
    import olc_pkg::*;
    t_entry r_e;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.vld <= 1'b0;
        end else if (i_shift) begin
            r_e <= i_prev;
        end
    end
    assign o_entry = r_e;
endmodule

>>> rtl/core/olc_div.sv
// ---------------------------------------------------------------------------
// olc_div
// Restoring divider, one quotient bit per cycle, rounds half away from zero.
// ---------------------------------------------------------------------------
module olc_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [olc_pkg::CtrW-1:0] i_num,
    input  logic [olc_pkg::DivW-1:0] i_den,
    output logic                     o_done,
    output logic [olc_pkg::CtrW-1:0] o_quo
);
    import olc_pkg::*;
    localparam int NW = CtrW + 1;
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0]   r_n;
    logic [DivW:0]   r_rem;
    logic [DivW-1:0] r_d;
    logic [CW-1:0]   r_cnt;
    logic            r_busy, r_done;
    logic [DivW:0]   w_try;
    logic [DivW+1:0] w_sub;

    assign w_try = {r_rem[DivW-1:0], r_n[NW-1]};
    assign w_sub = {1'b0, w_try} - {2'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // numerator plus half divisor
                r_n    <= {1'b0, i_num} + NW'(i_den >> 1);
                r_d    <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_sub[DivW+1]) begin
                    r_rem <= w_sub[DivW:0];
                    r_n   <= {r_n[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_try;
                    r_n   <= {r_n[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quo  = r_n[CtrW-1:0];
endmodule

>>> rtl/core/online_leader_clustering_unit.sv
// ---------------------------------------------------------------------------
// online_leader_clustering_unit
// Sequential leader clustering with running-mean centers, ring of cells.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis: tdata = {end_frame[31:16], start_frame[15:0]}, one point per beat.
//   m_axis: tdata = {center_end_out, center_start_out, dropped_full,
//           opened_new, cluster_index} (index at bit 0), padded to 64 bits.
//   Config: i_cfg_we/i_cfg_idx/i_cfg_wdata, 0 period, 1 start var, 2 end var.
//   Each point walks the full 64-cell ring once to find the nearest center
//   (one cell compared per cycle behind a 2-stage distance pipe, which then
//   drains), is tested against the gate, then a second lap writes the updated
//   entry back; a join first runs two serial divides (25 quotient bits each).
//   One point is in work at a time; the input is ready again in the cycle
//   the result is posted.
//   The result is held in an output register; while the receiver stalls
//   the next point is accepted and waits at the result handshake.
//   Reset empties the table (valid bits clear) and restores register defaults.
// ---------------------------------------------------------------------------
module online_leader_clustering_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // start_frame, end_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // index, opened, dropped, cs, ce
    input  logic        i_cfg_we,
    input  logic [olc_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [olc_pkg::RegW-1:0]    i_cfg_wdata
);
    import olc_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_SCAN = 7'b0000010, S_DRAIN = 7'b0000100,
        S_SEEK = 7'b0001000, S_DIV1 = 7'b0010000, S_DIV2 = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_st;
    logic [RegW-1:0] r_per, r_svar, r_evar;
    logic [CtrW-1:0] r_ps, r_pe;
    logic [NumW-1:0] r_used;
    logic [IdxW:0]   r_pos;     // cells rotated this lap
    logic [IdxW-1:0] r_best, r_tgt;
    logic [2*CtrW:0] r_bestd;
    logic            r_found;
    // distance pipe
    logic [CtrW-1:0] r_ds, r_de;
    logic [IdxW-1:0] r_p1idx, r_p2idx;
    logic            r_p1v, r_p2v;
    logic [2*CtrW-1:0] r_sq_s, r_sq_e;
    t_entry r_sel;
    logic   r_join, r_open, r_drop;
    logic [CtrW-1:0] r_ncs, r_nce;
    logic        r_ov;
    logic [63:0] r_od;

    t_entry w_cells [MaxClusters];
    t_chain_ctl w_ctl;
    t_entry w_head_in;

    // ring: cell 0 is head, gets tail or write data
    assign w_head_in = w_ctl.wr ? w_ctl.wdata : w_cells[MaxClusters-1];
    for (genvar g = 0; g < MaxClusters; g++) begin : g_cell
        olc_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(w_ctl.shift),
            .i_prev(g == 0 ? w_head_in : w_cells[(g + MaxClusters - 1) % MaxClusters]),
            .o_entry(w_cells[g])
        );
    end
    t_entry w_tail;
    assign w_tail = w_cells[MaxClusters-1];

    function automatic logic [CtrW-1:0] f_ad(logic [CtrW-1:0] a, logic [CtrW-1:0] b);
        return a >= b ? a - b : b - a;
    endfunction

    // gate, one multiply each side
    logic [CtrW-1:0] w_ms, w_me;
    logic [CtrW+RegW-1:0] w_lhs_s, w_lhs_e;
    logic [RegW+18-1:0]   w_rhs_s, w_rhs_e;
    logic w_pass;
    assign w_ms = f_ad(r_ps, r_sel.cs);
    assign w_me = f_ad(r_pe, r_sel.ce);
    assign w_lhs_s = w_ms * r_per;
    assign w_lhs_e = w_me * r_per;
    assign w_rhs_s = ({18'b0, r_svar} * (RegW+18)'(5)) << 15;
    assign w_rhs_e = ({18'b0, r_evar} * (RegW+18)'(5)) << 15;
    assign w_pass = ((CtrW+RegW+1)'(w_lhs_s) <= (CtrW+RegW+1)'(w_rhs_s))
                 && ((CtrW+RegW+1)'(w_lhs_e) <= (CtrW+RegW+1)'(w_rhs_e));

    // divider
    logic w_dstart, w_ddone;
    logic [CtrW-1:0] w_dnum, w_quo;
    logic [DivW-1:0] w_den;
    assign w_den  = {1'b0, r_sel.cnt} + DivW'(1);
    assign w_dnum = (r_st == S_DIV1) ? w_ms : w_me;
    olc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart), .i_num(w_dnum),
        .i_den(w_den), .o_done(w_ddone), .o_quo(w_quo)
    );
    logic r_dgo;
    assign w_dstart = r_dgo;

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

    logic [2*CtrW:0] w_d2;
    assign w_d2 = {1'b0, r_sq_s} + {1'b0, r_sq_e};

    always_comb begin
        w_ctl = '0;
        w_ctl.wdata.cs  = r_ncs;
        w_ctl.wdata.ce  = r_nce;
        w_ctl.wdata.vld = 1'b1;
        w_ctl.wdata.cnt = r_open ? CntW'(1)
                        : (&r_sel.cnt ? r_sel.cnt : r_sel.cnt + 1'b1);
        if (r_st == S_SCAN) w_ctl.shift = 1'b1;
        if (r_st == S_SEEK) begin
            // ring holds still in the gate cycle, so the lap stays 64 shifts
            w_ctl.shift = !(r_pos == '0 && !r_join && !r_open && !r_drop);
            // entry k passes the head at lap position 63 - k
            w_ctl.wr = (r_pos[IdxW-1:0] == ~r_tgt) && (r_join || r_open) && !r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_per  <= RegW'(65536);
            r_svar <= RegW'(256);
            r_evar <= RegW'(256);
            r_used <= '0;
            r_ov   <= 1'b0;
            r_dgo  <= 1'b0;
            r_p1v  <= 1'b0;
            r_p2v  <= 1'b0;
        end else begin
            r_dgo <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CfgPeriod: r_per  <= i_cfg_wdata;
                    CfgSVar:   r_svar <= i_cfg_wdata;
                    CfgEVar:   r_evar <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            // distance pipe, fed from the tail as cells rotate (index 63 first)
            r_p1v   <= (r_st == S_SCAN) && w_tail.vld;
            r_p1idx <= ~r_pos[IdxW-1:0];
            r_ds    <= f_ad(r_ps, w_tail.cs);
            r_de    <= f_ad(r_pe, w_tail.ce);
            r_p2v   <= r_p1v;
            r_p2idx <= r_p1idx;
            r_sq_s  <= r_ds * r_ds;
            r_sq_e  <= r_de * r_de;
            // scan runs downward, so an equal distance moves to the lower index
            if (r_p2v && (!r_found || w_d2 <= r_bestd)) begin
                r_found <= 1'b1;
                r_bestd <= w_d2;
                r_best  <= r_p2idx;
            end
            // tail index: cells are stored so index k sits at cell k at lap start
            unique case (r_st)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_ps    <= {s_axis_tdata[15:0], FracBits'(0)};
                        r_pe    <= {s_axis_tdata[31:16], FracBits'(0)};
                        r_pos   <= '0;
                        r_found <= 1'b0;
                        r_st    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pos <= r_pos + 1'b1;
                    if (r_pos == (IdxW+1)'(MaxClusters-1)) r_st <= S_DRAIN;
                end
                S_DRAIN: begin
                    // wait for pipe to empty, then select entry
                    if (!r_p1v && !r_p2v) begin
                        r_sel  <= w_cells[r_best];
                        r_pos  <= '0;
                        r_join <= 1'b0;
                        r_open <= 1'b0;
                        r_drop <= 1'b0;
                        r_st   <= S_SEEK;
                        if (!r_found) begin
                            r_open <= 1'b1;
                            r_tgt  <= '0;
                            r_ncs  <= r_ps;
                            r_nce  <= r_pe;
                        end
                        r_found <= 1'b0;
                    end
                end
                S_SEEK: begin
                    if (r_pos == '0 && !r_join && !r_open && !r_drop) begin
                        // first seek cycle decides outcome
                        r_pos <= r_pos;
                        if (w_pass) begin
                            r_join <= 1'b1;
                            r_tgt  <= r_best;
                            r_dgo  <= 1'b1;
                            r_st   <= S_DIV1;
                        end else if (r_used < NumW'(MaxClusters)) begin
                            r_open <= 1'b1;
                            r_tgt  <= r_used[IdxW-1:0];
                            r_ncs  <= r_ps;
                            r_nce  <= r_pe;
                        end else begin
                            r_drop <= 1'b1;
                            r_tgt  <= r_best;
                            r_ncs  <= r_sel.cs;
                            r_nce  <= r_sel.ce;
                        end
                    end else begin
                        r_pos <= r_pos + 1'b1;
                        if (r_pos == (IdxW+1)'(MaxClusters-1)) r_st <= S_OUT;
                    end
                end
                S_DIV1: begin
                    if (w_ddone) begin
                        r_ncs <= (r_ps >= r_sel.cs) ? r_sel.cs + w_quo : r_sel.cs - w_quo;
                        r_dgo <= 1'b1;
                        r_st  <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (w_ddone) begin
                        r_nce <= (r_pe >= r_sel.ce) ? r_sel.ce + w_quo : r_sel.ce - w_quo;
                        r_pos <= '0;
                        r_st  <= S_SEEK;
                    end
                end
                S_OUT: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        r_od <= {8'b0, r_nce, r_ncs, r_drop, r_open, r_tgt};
                        if (r_open) r_used <= r_used + 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_used_max, i_clk, i_rst_n, 1'b1, r_used <= NumW'(MaxClusters))
    `ASSERT_IMPL(a_one_outcome, i_clk, i_rst_n, r_st == S_OUT,
        !(r_join && r_open) && !(r_join && r_drop) && !(r_open && r_drop))
    `ASSERT_NEXT(a_used_step, i_clk, i_rst_n, r_st == S_IDLE && s_axis_tvalid,
        r_used == $past(r_used))
endmodule

>>> test/tb_online_leader_clustering_unit.sv
// ----------------------------------------------------------------------------
// Leader clustering unit regression
// Streams 2-D track points through the unit under several gate settings and
// handshake idling patterns, and checks every result beat against an
// in-bench cluster table that tracks the running-mean centers.
// ----------------------------------------------------------------------------
module tb_online_leader_clustering_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import olc_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int NumAnchors    = 96;
    localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

    typedef struct packed {
        logic [CtrW-1:0] ce;
        logic [CtrW-1:0] cs;
        logic            dropped;
        logic            opened;
        logic [IdxW-1:0] idx;
    } t_assign;

    typedef struct {
        logic [15:0] s;
        logic [15:0] e;
        bit          typed;
        t_assign     res;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata = '0;   // start_frame, end_frame
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [63:0]         m_axis_tdata;        // index, opened, dropped, cs, ce
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [RegW-1:0]     i_cfg_wdata = '0;

    online_leader_clustering_unit DUT (.*);

    always #2 i_clk = ~i_clk;

    // cluster table mirror
    logic [CtrW-1:0] start_ctr [MaxClusters];
    logic [CtrW-1:0] end_ctr   [MaxClusters];
    int unsigned     members   [MaxClusters];
    int unsigned     n_used;
    longint unsigned period_q16, svar_q8, evar_q8;

    t_assign assign_q[$];
    bit      typed_flag_q[$];
    t_assign typed_res_q[$];

    int      n_err, n_open, n_join, n_drop, idle_cycles;
    int      send_idle_pct, recv_stall_pct;
    logic [15:0] anchor_s [NumAnchors];
    logic [15:0] anchor_e [NumAnchors];

    function automatic longint unsigned mag_of(longint unsigned a, longint unsigned b);
        return a >= b ? a - b : b - a;
    endfunction

    function automatic bit in_gate(longint unsigned mag, longint unsigned spread);
        return mag * period_q16 <= ((64'd5 * spread) << 15);
    endfunction

    function automatic logic [CtrW-1:0] mean_step(longint unsigned c, longint unsigned p,
                                                  longint unsigned div);
        longint unsigned q;
        q = (mag_of(p, c) + div / 2) / div;
        return p >= c ? CtrW'(c + q) : CtrW'(c - q);
    endfunction

    function automatic t_assign cluster_point(logic [15:0] sf, logic [15:0] ef);
        longint unsigned ps, pe, d, best_d;
        int unsigned     best, k;
        t_assign         r;
        ps = longint'(sf) << FracBits;
        pe = longint'(ef) << FracBits;
        best = 0;
        best_d = 0;
        r = '0;
        for (int j = 0; j < n_used; j++) begin
            d = mag_of(ps, start_ctr[j]) ** 2 + mag_of(pe, end_ctr[j]) ** 2;
            if (j == 0 || d < best_d) begin
                best = j;
                best_d = d;
            end
        end
        if (n_used != 0 && in_gate(mag_of(ps, start_ctr[best]), svar_q8)
                && in_gate(mag_of(pe, end_ctr[best]), evar_q8)) begin
            start_ctr[best] = mean_step(start_ctr[best], ps, members[best] + 1);
            end_ctr[best]   = mean_step(end_ctr[best], pe, members[best] + 1);
            if (members[best] < 65535) members[best]++;
            r.idx = IdxW'(best);
        end else if (n_used < MaxClusters) begin
            k = n_used;
            start_ctr[k] = CtrW'(ps);
            end_ctr[k]   = CtrW'(pe);
            members[k]   = 1;
            n_used++;
            r.idx = IdxW'(k);
            r.opened = 1'b1;
        end else begin
            r.idx = IdxW'(best);
            r.dropped = 1'b1;
        end
        r.cs = start_ctr[r.idx];
        r.ce = end_ctr[r.idx];
        return r;
    endfunction

    // beat monitor: predict on input accept, compare on output accept
    always @(posedge i_clk) begin
        t_assign want, got, pred;
        bit      typed;
        t_assign typed_res;
        if (i_rst_n) begin
            idle_cycles = idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                idle_cycles = 0;
                got = t_assign'(m_axis_tdata[$bits(t_assign)-1:0]);
                if (got.opened) n_open++;
                else if (got.dropped) n_drop++;
                else n_join++;
                if (assign_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result beat %h", m_axis_tdata);
                end else begin
                    want = assign_q.pop_front();
                    if (got !== want || m_axis_tdata[63:$bits(t_assign)] !== '0) begin
                        n_err++;
                        if (n_err <= 10) begin
                            $display("mismatch: exp idx %0d op %b dr %b cs %h ce %h",
                                     want.idx, want.opened, want.dropped, want.cs, want.ce);
                            $display("          got idx %0d op %b dr %b cs %h ce %h",
                                     got.idx, got.opened, got.dropped, got.cs, got.ce);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                idle_cycles = 0;
                pred = cluster_point(s_axis_tdata[15:0], s_axis_tdata[31:16]);
                typed = typed_flag_q.pop_front();
                typed_res = typed_res_q.pop_front();
                assign_q = {assign_q, (typed ? typed_res : pred)};
            end
            if (idle_cycles >= WatchdogLimit) begin
                $display("watchdog: no beat for %0d cycles", WatchdogLimit);
                $display("online_leader_clustering_unit regression: fail");
                $finish;
            end
        end
    end

    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_point(logic [15:0] sf, logic [15:0] ef, bit typed, t_assign res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        typed_flag_q = {typed_flag_q, typed};
        typed_res_q  = {typed_res_q, res};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ef, sf};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // only called with nothing in flight
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CfgPeriod: period_q16 = val;
            CfgSVar:   svar_q8 = val;
            CfgEVar:   evar_q8 = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (assign_q.size() != 0 || typed_flag_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_points(int count);
        int a, ds, de, s, e;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 80) begin
                a  = $urandom_range(NumAnchors - 1);
                ds = int'($urandom_range(6)) - 3;
                de = int'($urandom_range(6)) - 3;
                s  = int'(anchor_s[a]) + ds;
                e  = int'(anchor_e[a]) + de;
                s  = s < 0 ? 0 : (s > 65535 ? 65535 : s);
                e  = e < 0 ? 0 : (e > 65535 ? 65535 : e);
                send_point(16'(s), 16'(e), 1'b0, '0);
            end else begin
                send_point(16'($urandom), 16'($urandom), 1'b0, '0);
            end
        end
        drain();
    endtask

    t_row rows[$];

    initial begin
        n_err = 0; n_open = 0; n_join = 0; n_drop = 0; idle_cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        period_q16 = 65536; svar_q8 = 256; evar_q8 = 256;
        n_used = 0;
        foreach (members[i]) begin
            members[i] = 0; start_ctr[i] = '0; end_ctr[i] = '0;
        end
        foreach (anchor_s[i]) begin
            anchor_s[i] = 16'($urandom);
            anchor_e[i] = 16'($urandom);
        end
        rows = '{
            '{16'd0,     16'd0,     1, '{ce: 24'h0,      cs: 24'h0,      dropped: 0, opened: 1, idx: 0}},
            '{16'hFFFF,  16'hFFFF,  1, '{ce: 24'hFFFF00, cs: 24'hFFFF00, dropped: 0, opened: 1, idx: 1}},
            '{16'd1,     16'd0,     0, '0},
            '{16'hFFFF,  16'hFFFE,  0, '0},
            '{16'd0,     16'd2,     0, '0},
            '{16'h8000,  16'd0,     1, '{ce: 24'h0,      cs: 24'h800000, dropped: 0, opened: 1, idx: 2}},
            '{16'd0,     16'hFFFF,  1, '{ce: 24'hFFFF00, cs: 24'h0,      dropped: 0, opened: 1, idx: 3}},
            '{16'h5555,  16'hAAAA,  1, '{ce: 24'hAAAA00, cs: 24'h555500, dropped: 0, opened: 1, idx: 4}},
            '{16'hAAAA,  16'h5555,  1, '{ce: 24'h555500, cs: 24'hAAAA00, dropped: 0, opened: 1, idx: 5}},
            '{16'd3,     16'd1,     0, '0},
            '{16'h8002,  16'd2,     0, '0},
            '{16'd0,     16'd3,     0, '0},
            '{16'h5557,  16'hAAA8,  0, '0},
            '{16'hAAAD,  16'h5555,  0, '0}
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) send_point(rows[r].s, rows[r].e, rows[r].typed, rows[r].res);
        random_points(400);

        // wider gate, sender idling
        write_reg(CfgPeriod, 24'hFFFFFF);
        write_reg(CfgSVar, 24'hFFFFFF);
        write_reg(CfgEVar, 24'hFFFFFF);
        send_idle_pct = 47;
        random_points(400);

        // zero period passes every point; unused index must be ignored
        write_reg(CfgPeriod, 24'h0);
        write_reg(CfgSVar, 24'h0);
        write_reg(CfgEVar, 24'h0);
        write_reg(CfgUnused, 24'h5A5A5A);
        send_idle_pct = 0;
        recv_stall_pct = 47;
        random_points(200);

        // zero start spread: only exact start matches join
        write_reg(CfgPeriod, 24'h008000);
        write_reg(CfgEVar, 24'h000200);
        random_points(200);

        write_reg(CfgPeriod, 24'h010000);
        write_reg(CfgSVar, 24'h000100);
        write_reg(CfgEVar, 24'h000100);
        send_idle_pct = 18;
        recv_stall_pct = 18;
        random_points(450);

        repeat (300) @(posedge i_clk);
        $display("covered %0d opens, %0d joins, %0d drops on a full table",
                 n_open, n_join, n_drop);
        $display("over five gate settings and four idling patterns");
        if (n_err == 0) begin
            $display("online_leader_clustering_unit regression: pass");
        end else begin
            $display("%0d mismatches", n_err);
            $display("online_leader_clustering_unit regression: fail");
        end
        $finish;
    end
endmodule
